FILE: design/urff_pkg.sv
// Shared types, constants and the digit-to-ASCII map for the unsigned field formatter.
package urff_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIG_DEPTH = 16;
    localparam int unsigned DIG_IDX_W = 4;
    localparam int unsigned CHAR_W    = 8;

    // floor(v / 10) == (v * RECIP10) >> RECIP10_SHIFT for every 32-bit v
    localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP10_SHIFT = 35;
    localparam int unsigned        QUOT_W        = 2 * VALUE_W - RECIP10_SHIFT;

    localparam logic [1:0] RADIX_DEC   = 2'd0;
    localparam logic [1:0] RADIX_HEX_L = 2'd1;
    localparam logic [1:0] RADIX_HEX_U = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] TEN        = 8'd10;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_PLAN = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] d8;
        d8 = {4'b0000, d};
        if (d8 < TEN)
            digit_char = CHAR_ZERO + d8;
        else if (upper)
            digit_char = CHAR_UP_A + d8 - TEN;
        else
            digit_char = CHAR_LOW_A + d8 - TEN;
    endfunction

endpackage

FILE: design/unsigned_radix_field_formatter_top.sv
// Top level of the unsigned printf-style field formatter.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_ready  | value, radix_mode, field_width, precision,
//           |                      | left_justify, zero_flag
//   out     | out_valid / out_ready| char_out, last (one character per item)
//
// Decimal digits come from a multiply-by-reciprocal step (multiply, then remainder);
// hex digits come from shifting the value right by four.
// A planning state sizes the padding, then one character leaves per cycle
// while out_ready is high: at most MAX_FIELD characters.
// in_ready is high only in idle; a field with no characters returns to idle silently.
// rst_n clears the sequencer and the output valid; the digit buffer needs no reset.
module unsigned_radix_field_formatter_top
    import urff_pkg::*;
#(
    parameter int unsigned MAX_FIELD = 64
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         value,
    input  logic [1:0]          radix_mode,
    input  logic [6:0]          field_width,
    input  logic signed [7:0]   precision,
    input  logic                left_justify,
    input  logic                zero_flag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   char_out,
    output logic                last
);

    localparam int unsigned CW = $clog2(MAX_FIELD + 1);
    localparam logic [6:0]  MAXF7 = 7'(MAX_FIELD);

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     work_reg, work_next;
    logic [QUOT_W-1:0]      quot_reg, quot_next;
    logic [3:0]             dig_reg [DIG_DEPTH];
    logic [DIG_IDX_W-1:0]   nd_reg, nd_next;
    logic                   hex_reg, hex_next;
    logic                   upper_reg, upper_next;
    logic                   lj_reg, lj_next;
    logic                   pad_zero_reg, pad_zero_next;
    logic                   has_prec_reg, has_prec_next;
    logic                   zero_case_reg, zero_case_next;
    logic [CW-1:0]          width_reg, width_next;
    logic [CW-1:0]          prec_reg, prec_next;
    logic [CW-1:0]          lead_reg, lead_next;
    logic [CW-1:0]          zfill_reg, zfill_next;
    logic [CW-1:0]          trail_reg, trail_next;
    logic [CW-1:0]          left_reg, left_next;
    logic [DIG_IDX_W-1:0]   didx_reg, didx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   accept;
    logic                   load;
    logic                   dig_we;
    logic [3:0]             dig_wdata;
    logic [2*VALUE_W-1:0]   product;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     quot_x10;
    logic [VALUE_W-1:0]     rem_full;
    logic [CW-1:0]          nd_eff;
    logic [CW-1:0]          body;
    logic [CW-1:0]          pad;
    logic [CW-1:0]          total;
    logic [DIG_IDX_W-1:0]   didx_m1;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign load      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    // shared divide step: reciprocal multiply feeds quot_reg, remainder by shift-add
    assign product  = work_reg * RECIP10;
    assign quot     = hex_reg ? (work_reg >> 4) : VALUE_W'(quot_reg);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = work_reg - quot_x10;
    assign dig_wdata = hex_reg ? work_reg[3:0] : rem_full[3:0];
    assign dig_we    = (state_reg == S_DIV);

    assign nd_eff  = zero_case_reg ? '0 : CW'(nd_reg);
    assign body    = (has_prec_reg && prec_reg > nd_eff) ? prec_reg : nd_eff;
    assign pad     = (width_reg > body) ? width_reg - body : '0;
    assign total   = body + pad;
    assign didx_m1 = didx_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        quot_next      = quot_reg;
        nd_next        = nd_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        lj_next        = lj_reg;
        pad_zero_next  = pad_zero_reg;
        has_prec_next  = has_prec_reg;
        zero_case_next = zero_case_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        lead_next      = lead_reg;
        zfill_next     = zfill_reg;
        trail_next     = trail_reg;
        left_next      = left_reg;
        didx_next      = didx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    work_next      = value;
                    nd_next        = '0;
                    hex_next       = (radix_mode == RADIX_HEX_L) || (radix_mode == RADIX_HEX_U);
                    upper_next     = (radix_mode == RADIX_HEX_U);
                    lj_next        = left_justify;
                    has_prec_next  = !precision[7];
                    pad_zero_next  = !left_justify && zero_flag && precision[7];
                    zero_case_next = (value == '0) && (precision == 8'sd0);
                    width_next     = (field_width > MAXF7) ? CW'(MAX_FIELD) : CW'(field_width);
                    if (precision[7])
                        prec_next = '0;
                    else if (precision[6:0] > MAXF7)
                        prec_next = CW'(MAX_FIELD);
                    else
                        prec_next = CW'(precision[6:0]);
                    state_next = ((radix_mode == RADIX_HEX_L) || (radix_mode == RADIX_HEX_U))
                                 ? S_DIV : S_MUL;
                end
            end
            S_MUL:
            begin
                quot_next  = product[2*VALUE_W-1:RECIP10_SHIFT];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                nd_next   = nd_reg + 1'b1;
                work_next = quot;
                if (quot == '0)
                    state_next = S_PLAN;
                else
                    state_next = hex_reg ? S_DIV : S_MUL;
            end
            S_PLAN:
            begin
                lead_next  = lj_reg ? '0 : pad;
                trail_next = lj_reg ? pad : '0;
                zfill_next = body - nd_eff;
                didx_next  = DIG_IDX_W'(nd_eff);
                left_next  = total;
                state_next = (total == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    last_next      = (left_reg == CW'(1));
                    left_next      = left_reg - 1'b1;
                    if (lead_reg != '0)
                    begin
                        char_next = pad_zero_reg ? CHAR_ZERO : CHAR_SPACE;
                        lead_next = lead_reg - 1'b1;
                    end
                    else if (zfill_reg != '0)
                    begin
                        char_next  = CHAR_ZERO;
                        zfill_next = zfill_reg - 1'b1;
                    end
                    else if (didx_reg != '0)
                    begin
                        char_next = digit_char(dig_reg[didx_m1], upper_reg);
                        didx_next = didx_m1;
                    end
                    else
                    begin
                        char_next  = CHAR_SPACE;
                        trail_next = trail_reg - 1'b1;
                    end
                    if (left_reg == CW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // digit buffer, least significant digit first
    always_ff @(posedge clk)
    begin
        if (dig_we)
            dig_reg[nd_reg] <= dig_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        quot_reg      <= quot_next;
        nd_reg        <= nd_next;
        hex_reg       <= hex_next;
        upper_reg     <= upper_next;
        lj_reg        <= lj_next;
        pad_zero_reg  <= pad_zero_next;
        has_prec_reg  <= has_prec_next;
        zero_case_reg <= zero_case_next;
        width_reg     <= width_next;
        prec_reg      <= prec_next;
        lead_reg      <= lead_next;
        zfill_reg     <= zfill_next;
        trail_reg     <= trail_next;
        left_reg      <= left_next;
        didx_reg      <= didx_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
    end

endmodule
